FILE: rtl/core/tse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_pkg: shared types and constants of the topological sort engine
// Beat payloads, opcodes, sequencer states and parameter defaults.
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int NODE_W        = 7;
    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;

    typedef logic [NODE_W-1:0] t_node;

    localparam t_node NODE_CNT_RST = 7'd64;

    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_RUN      = 1'b1;

    typedef struct packed {
        logic  opcode;
        t_node source_node;
        t_node target_node;
    } t_item;

    typedef struct packed {
        t_node node_id;
        logic  cycle_found;
        logic  edge_error;
        logic  last;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_WR,
        ST_SEED_RD,
        ST_SEED_CK,
        ST_POP_RD,
        ST_POP_LD,
        ST_SCAN_RD,
        ST_SCAN_CK,
        ST_SCAN_UPD,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_EMIT_CYC
    } t_state;

endpackage

FILE: rtl/core/tse_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_chan_if: valid/ready channel
// One beat moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface tse_chan_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/tse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tse_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/tse_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tse_engine: Kahn sort sequencer
// Edge store, in-degree memory with valid bits, ready FIFO and the shared
// in-degree adjust/compare unit, all stepped by one state machine.
// ----------------------------------------------------------------------------
module tse_engine #(
    parameter int MAX_NODES = tse_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = tse_pkg::MAX_EDGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tse_pkg::t_node    i_node_cnt,
    input  logic              i_item_valid,
    input  tse_pkg::t_item    i_item,
    output logic              o_item_ready,
    output logic              o_res_valid,
    output tse_pkg::t_result  o_res,
    input  logic              i_res_ready
);

    localparam int NW    = tse_pkg::NODE_W;
    localparam int NA_W  = $clog2(MAX_NODES);
    localparam int QC_W  = $clog2(MAX_NODES + 1);
    localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W  = $clog2(MAX_EDGES + 1);
    localparam int DEG_W = EC_W;

    tse_pkg::t_state r_state, n_state;

    logic [EC_W-1:0]      r_edges_stored;
    logic [EC_W-1:0]      r_edge_idx;
    logic [QC_W-1:0]      r_head;
    logic [QC_W-1:0]      r_tail;
    logic [QC_W-1:0]      r_emit_idx;
    logic [NW-1:0]        r_node;
    logic [NW-1:0]        r_now;
    logic [NW-1:0]        r_tgt;
    logic                 r_err;
    logic [MAX_NODES-1:0] r_deg_valid;

    // RAM ports
    logic                 edge_wr_en, edge_rd_en;
    logic [2*NW-1:0]      edge_wr_data, edge_rd_data;
    logic                 deg_wr_en, deg_rd_en;
    logic [NA_W-1:0]      deg_wr_addr, deg_rd_addr;
    logic [DEG_W-1:0]     deg_wr_data, deg_rd_data;
    logic                 fifo_wr_en, fifo_rd_en;
    logic [NA_W-1:0]      fifo_rd_addr;
    logic [NW-1:0]        fifo_wr_data, fifo_rd_data;

    logic                 accept, is_add, edge_ok;
    logic [NW-1:0]        e_src, e_tgt;
    logic                 scan_hit, scan_end, emit_last;
    logic [NA_W-1:0]      tgt_idx, node_idx, deg_slot;
    logic [DEG_W-1:0]     deg_cur, deg_adj;
    logic                 deg_zero, deg_one;

    assign accept  = i_item_valid && o_item_ready;
    assign is_add  = (i_item.opcode == tse_pkg::OP_ADD_EDGE);
    assign edge_ok = (i_item.source_node != '0) && (i_item.source_node <= i_node_cnt)
                  && (i_item.target_node != '0) && (i_item.target_node <= i_node_cnt)
                  && (r_edges_stored < EC_W'(MAX_EDGES));

    assign e_src    = edge_rd_data[2*NW-1:NW];
    assign e_tgt    = edge_rd_data[NW-1:0];
    // stale edges may name a target above the current node count
    assign scan_hit = (e_src == r_now) && (e_tgt != '0) && (e_tgt <= i_node_cnt);
    assign scan_end = (r_edge_idx + EC_W'(1)) == r_edges_stored;
    assign emit_last = (NW'(r_emit_idx) + NW'(1)) == i_node_cnt;

    assign tgt_idx  = NA_W'(r_tgt - NW'(1));
    assign node_idx = NA_W'(r_node - NW'(1));
    assign deg_slot = (r_state == tse_pkg::ST_SEED_CK) ? node_idx : tgt_idx;

    // shared in-degree unit: never-written entries read as zero
    assign deg_cur  = r_deg_valid[deg_slot] ? deg_rd_data : '0;
    assign deg_adj  = (r_state == tse_pkg::ST_EDGE_WR) ? deg_cur + DEG_W'(1)
                                                       : deg_cur - DEG_W'(1);
    assign deg_zero = (deg_cur == '0);
    assign deg_one  = (deg_cur == DEG_W'(1));

    assign edge_wr_data = {i_item.source_node, i_item.target_node};
    assign deg_wr_addr  = tgt_idx;
    assign deg_wr_data  = deg_adj;
    assign fifo_wr_data = (r_state == tse_pkg::ST_SCAN_UPD) ? r_tgt : r_node;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tse_pkg::ST_IDLE: begin
                if (accept) begin
                    if (is_add) begin
                        n_state = edge_ok ? tse_pkg::ST_EDGE_WR : tse_pkg::ST_IDLE;
                    end else begin
                        n_state = tse_pkg::ST_SEED_RD;
                    end
                end
            end
            tse_pkg::ST_EDGE_WR: n_state = tse_pkg::ST_IDLE;
            tse_pkg::ST_SEED_RD: n_state = tse_pkg::ST_SEED_CK;
            tse_pkg::ST_SEED_CK: begin
                n_state = (r_node == i_node_cnt) ? tse_pkg::ST_POP_RD : tse_pkg::ST_SEED_RD;
            end
            tse_pkg::ST_POP_RD: begin
                n_state = (r_head == r_tail) ? tse_pkg::ST_CHECK : tse_pkg::ST_POP_LD;
            end
            tse_pkg::ST_POP_LD: begin
                n_state = (r_edges_stored == '0) ? tse_pkg::ST_POP_RD : tse_pkg::ST_SCAN_RD;
            end
            tse_pkg::ST_SCAN_RD: n_state = tse_pkg::ST_SCAN_CK;
            tse_pkg::ST_SCAN_CK: begin
                if (scan_hit) begin
                    n_state = tse_pkg::ST_SCAN_UPD;
                end else begin
                    n_state = scan_end ? tse_pkg::ST_POP_RD : tse_pkg::ST_SCAN_RD;
                end
            end
            tse_pkg::ST_SCAN_UPD: begin
                n_state = scan_end ? tse_pkg::ST_POP_RD : tse_pkg::ST_SCAN_RD;
            end
            tse_pkg::ST_CHECK: begin
                n_state = (NW'(r_tail) == i_node_cnt) ? tse_pkg::ST_EMIT_RD
                                                      : tse_pkg::ST_EMIT_CYC;
            end
            tse_pkg::ST_EMIT_RD: n_state = tse_pkg::ST_EMIT_OUT;
            tse_pkg::ST_EMIT_OUT: begin
                if (i_res_ready) begin
                    n_state = emit_last ? tse_pkg::ST_IDLE : tse_pkg::ST_EMIT_RD;
                end
            end
            tse_pkg::ST_EMIT_CYC: begin
                if (i_res_ready) begin
                    n_state = tse_pkg::ST_IDLE;
                end
            end
            default: n_state = tse_pkg::ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = '0;
        edge_wr_en   = 1'b0;
        edge_rd_en   = 1'b0;
        deg_wr_en    = 1'b0;
        deg_rd_en    = 1'b0;
        deg_rd_addr  = node_idx;
        fifo_wr_en   = 1'b0;
        fifo_rd_en   = 1'b0;
        fifo_rd_addr = r_head[NA_W-1:0];
        unique case (r_state)
            tse_pkg::ST_IDLE: begin
                o_item_ready = 1'b1;
                edge_wr_en   = accept && is_add && edge_ok;
                deg_rd_en    = accept && is_add && edge_ok;
                deg_rd_addr  = NA_W'(i_item.target_node - NW'(1));
            end
            tse_pkg::ST_EDGE_WR: begin
                deg_wr_en = 1'b1;
            end
            tse_pkg::ST_SEED_RD: begin
                deg_rd_en = 1'b1;
            end
            tse_pkg::ST_SEED_CK: begin
                fifo_wr_en = deg_zero;
            end
            tse_pkg::ST_POP_RD: begin
                fifo_rd_en = (r_head != r_tail);
            end
            tse_pkg::ST_POP_LD: begin
            end
            tse_pkg::ST_SCAN_RD: begin
                edge_rd_en = 1'b1;
            end
            tse_pkg::ST_SCAN_CK: begin
                deg_rd_en   = scan_hit;
                deg_rd_addr = NA_W'(e_tgt - NW'(1));
            end
            tse_pkg::ST_SCAN_UPD: begin
                deg_wr_en  = !deg_zero;
                fifo_wr_en = deg_one;
            end
            tse_pkg::ST_CHECK: begin
            end
            tse_pkg::ST_EMIT_RD: begin
                fifo_rd_en   = 1'b1;
                fifo_rd_addr = r_emit_idx[NA_W-1:0];
            end
            tse_pkg::ST_EMIT_OUT: begin
                o_res_valid       = 1'b1;
                o_res.node_id     = fifo_rd_data;
                o_res.cycle_found = 1'b0;
                o_res.edge_error  = r_err;
                o_res.last        = emit_last;
            end
            tse_pkg::ST_EMIT_CYC: begin
                o_res_valid       = 1'b1;
                o_res.node_id     = '0;
                o_res.cycle_found = 1'b1;
                o_res.edge_error  = r_err;
                o_res.last        = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tse_pkg::ST_IDLE;
            r_edges_stored <= '0;
            r_edge_idx     <= '0;
            r_head         <= '0;
            r_tail         <= '0;
            r_emit_idx     <= '0;
            r_err          <= 1'b0;
            r_deg_valid    <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                tse_pkg::ST_IDLE: begin
                    if (accept) begin
                        if (is_add) begin
                            if (edge_ok) begin
                                r_tgt <= i_item.target_node;
                            end else begin
                                r_err <= 1'b1;
                            end
                        end else begin
                            r_node <= NW'(1);
                            r_head <= '0;
                            r_tail <= '0;
                        end
                    end
                end
                tse_pkg::ST_EDGE_WR: begin
                    r_edges_stored       <= r_edges_stored + EC_W'(1);
                    r_deg_valid[tgt_idx] <= 1'b1;
                end
                tse_pkg::ST_SEED_CK: begin
                    if (deg_zero) begin
                        r_tail <= r_tail + QC_W'(1);
                    end
                    r_node <= r_node + NW'(1);
                end
                tse_pkg::ST_POP_LD: begin
                    r_now      <= fifo_rd_data;
                    r_head     <= r_head + QC_W'(1);
                    r_edge_idx <= '0;
                end
                tse_pkg::ST_SCAN_CK: begin
                    if (scan_hit) begin
                        r_tgt <= e_tgt;
                    end else begin
                        r_edge_idx <= r_edge_idx + EC_W'(1);
                    end
                end
                tse_pkg::ST_SCAN_UPD: begin
                    if (deg_one) begin
                        r_tail <= r_tail + QC_W'(1);
                    end
                    r_edge_idx <= r_edge_idx + EC_W'(1);
                end
                tse_pkg::ST_CHECK: begin
                    r_deg_valid    <= '0;
                    r_edges_stored <= '0;
                    r_emit_idx     <= '0;
                end
                tse_pkg::ST_EMIT_OUT: begin
                    if (i_res_ready) begin
                        r_emit_idx <= r_emit_idx + QC_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    tse_ram #(.WIDTH(2 * NW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (edge_wr_en),
        .i_wr_addr (r_edges_stored[EA_W-1:0]),
        .i_wr_data (edge_wr_data),
        .i_rd_en   (edge_rd_en),
        .i_rd_addr (r_edge_idx[EA_W-1:0]),
        .o_rd_data (edge_rd_data)
    );

    tse_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
        .i_clk     (i_clk),
        .i_wr_en   (deg_wr_en),
        .i_wr_addr (deg_wr_addr),
        .i_wr_data (deg_wr_data),
        .i_rd_en   (deg_rd_en),
        .i_rd_addr (deg_rd_addr),
        .o_rd_data (deg_rd_data)
    );

    // ready FIFO; its entries in order are also the emitted order
    tse_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fifo_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fifo_wr_en),
        .i_wr_addr (r_tail[NA_W-1:0]),
        .i_wr_data (fifo_wr_data),
        .i_rd_en   (fifo_rd_en),
        .i_rd_addr (fifo_rd_addr),
        .o_rd_data (fifo_rd_data)
    );

`ifndef SYNTH
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tse_pkg::ST_IDLE) |-> (r_head <= r_tail))
        else $error("FIFO head passed tail");

    // tail keeps the previous run's count until the next run starts
    a_tail_le_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != tse_pkg::ST_IDLE) && (r_state != tse_pkg::ST_EDGE_WR))
        |-> (NW'(r_tail) <= i_node_cnt))
        else $error("more nodes queued than exist");

    a_edges_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edges_stored <= EC_W'(MAX_EDGES))
        else $error("edge store overfilled");

    a_clear_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tse_pkg::ST_CHECK) |=> (r_deg_valid == '0) && (r_edges_stored == '0))
        else $error("in-degrees not cleared after run");

    a_cycle_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.cycle_found) |-> (o_res.last && (o_res.node_id == '0)))
        else $error("malformed cycle beat");
`endif

endmodule

FILE: rtl/core/topological_sort_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topological_sort_engine_core: Kahn topological sort engine
// Node count register, sort sequencer and result output register.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | beat
//  i_cfg   | in  | node_count (7b)                                 | always ready
//  i_in    | in  | opcode, source_node, target_node                | ready when idle
//  o_out   | out | node_id, cycle_found, edge_error, last          | output register
//
//  Edge beat: accept with in-degree read, then in-degree read-modify-write.
//  Run beat: a seed read and check per node, then per popped node a pop read and
//  load, a read and check per stored edge and an update per hit on the node;
//  then a FIFO read and an output beat per emitted node.
//  Reset is synchronous, active low; in-degrees are cleared by valid bits.
//  A stalled o_out holds the engine in its emit state; i_in stays not ready.
// ----------------------------------------------------------------------------
module topological_sort_engine_core #(
    parameter int MAX_NODES = tse_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = tse_pkg::MAX_EDGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tse_chan_if.sink    i_cfg,
    tse_chan_if.sink    i_in,
    tse_chan_if.source  o_out
);

    localparam int NW = tse_pkg::NODE_W;

    tse_pkg::t_node   r_node_count;
    tse_pkg::t_node   node_eff;
    tse_pkg::t_item   item;
    tse_pkg::t_result res;
    tse_pkg::t_result r_out;
    logic             r_out_valid;
    logic             item_ready;
    logic             res_valid;
    logic             res_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= tse_pkg::NODE_CNT_RST;
        end else if (i_cfg.valid) begin
            r_node_count <= NW'(i_cfg.payload);
        end
    end

    // saturate to 1..MAX_NODES
    always_comb begin
        priority if (r_node_count == '0) begin
            node_eff = NW'(1);
        end else if (r_node_count > NW'(MAX_NODES)) begin
            node_eff = NW'(MAX_NODES);
        end else begin
            node_eff = r_node_count;
        end
    end

    assign item       = i_in.payload;
    assign i_in.ready = item_ready;

    tse_engine #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_cnt   (node_eff),
        .i_item_valid (i_in.valid),
        .i_item       (item),
        .o_item_ready (item_ready),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

FILE: sim/topological_sort_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topological_sort_engine_core_test: self-checking bench of the sort engine
// Directed table, then random graphs (acyclic, cyclic, stale, malformed) and
// a full edge-store fill. Each run is predicted by a Kahn model in the bench, or
// by the row's own result if typed, and the output beats are compared in order.
// ----------------------------------------------------------------------------
module topological_sort_engine_core_test;

    typedef tse_pkg::t_node   t_node;
    typedef tse_pkg::t_item   t_item;
    typedef tse_pkg::t_result t_result;

    localparam int NODES_MAX = tse_pkg::MAX_NODES_DEF;
    localparam int EDGES_MAX = tse_pkg::MAX_EDGES_DEF;
    localparam int RAND_BEATS = 105;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_EDGE,
        ROW_RUN
    } t_row_kind;

    // ROW_CFG: a = node_count; ROW_EDGE: a -> b; ROW_RUN: a, b are don't-care fields
    typedef struct packed {
        t_row_kind kind;
        t_node     a;
        t_node     b;
        logic      typed;
        t_result   res;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{ROW_RUN,  7'd0,   7'd0,   1'b0, '0},                             // empty, n=64
        '{ROW_CFG,  7'd1,   7'd0,   1'b0, '0},
        '{ROW_RUN,  7'h7F,  7'h7F,  1'b1, '{7'd1, 1'b0, 1'b0, 1'b1}},
        '{ROW_EDGE, 7'd1,   7'd1,   1'b0, '0},                             // self loop
        '{ROW_RUN,  7'd0,   7'h7F,  1'b1, '{7'd0, 1'b1, 1'b0, 1'b1}},
        '{ROW_CFG,  7'd4,   7'd0,   1'b0, '0},
        '{ROW_EDGE, 7'd4,   7'd3,   1'b0, '0},
        '{ROW_EDGE, 7'd3,   7'd2,   1'b0, '0},
        '{ROW_EDGE, 7'd2,   7'd1,   1'b0, '0},
        '{ROW_EDGE, 7'd2,   7'd1,   1'b0, '0},                             // duplicate
        '{ROW_RUN,  7'h55,  7'h2A,  1'b0, '0},
        '{ROW_CFG,  7'd0,   7'd0,   1'b0, '0},                             // acts as 1
        '{ROW_RUN,  7'd0,   7'd0,   1'b1, '{7'd1, 1'b0, 1'b0, 1'b1}},
        '{ROW_CFG,  7'd127, 7'd0,   1'b0, '0},                             // acts as 64
        '{ROW_EDGE, 7'd64,  7'd63,  1'b0, '0},
        '{ROW_EDGE, 7'd1,   7'd64,  1'b0, '0},
        '{ROW_RUN,  7'd0,   7'd0,   1'b0, '0},
        '{ROW_EDGE, 7'd50,  7'd2,   1'b0, '0},                             // goes stale
        '{ROW_CFG,  7'd4,   7'd0,   1'b0, '0},
        '{ROW_RUN,  7'd0,   7'd0,   1'b1, '{7'd0, 1'b1, 1'b0, 1'b1}},
        '{ROW_EDGE, 7'd0,   7'd1,   1'b0, '0},                             // node zero
        '{ROW_EDGE, 7'd1,   7'd5,   1'b0, '0},                             // above n
        '{ROW_EDGE, 7'd1,   7'd2,   1'b0, '0},
        '{ROW_RUN,  7'd0,   7'd0,   1'b0, '0},
        '{ROW_CFG,  7'd64,  7'd0,   1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic out_rdy = 1'b0;

    tse_chan_if #(.T_PAYLOAD(t_node))   cfg_ch ();
    tse_chan_if #(.T_PAYLOAD(t_item))   in_ch ();
    tse_chan_if #(.T_PAYLOAD(t_result)) out_ch ();

    assign out_ch.ready = out_rdy;

    topological_sort_engine_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // model state of the engine
    t_node       edge_src_m [EDGES_MAX];
    t_node       edge_dst_m [EDGES_MAX];
    int unsigned edge_cnt_m;
    int unsigned indeg_m [NODES_MAX+1];
    logic        err_sticky_m;
    t_node       node_cnt_m;

    t_result     run_res [$];
    t_result     expected_order_q [$];

    int          snd_idle_pct = 23;
    int          rcv_idle_pct = 45;
    int          mismatch_cnt = 0;
    int          beat_cnt = 0;

    function automatic int unsigned nodes_eff();
        int unsigned n;
        n = node_cnt_m;
        if (n < 1) n = 1;
        if (n > NODES_MAX) n = NODES_MAX;
        return n;
    endfunction

    // applies a beat to the model: stores an edge, or Kahn-sorts the stored graph into run_res
    task automatic kahn_predict(input t_item it);
        int unsigned n;
        int unsigned tgt;
        t_node       now;
        t_node       ready_q [$];
        t_node       order_q [$];
        t_result     r;
        n = nodes_eff();
        run_res.delete();
        if (it.opcode == tse_pkg::OP_ADD_EDGE) begin
            if (it.source_node < 1 || it.source_node > n || it.target_node < 1 ||
                it.target_node > n || edge_cnt_m >= EDGES_MAX) begin
                err_sticky_m = 1'b1;
            end else begin
                edge_src_m[edge_cnt_m] = it.source_node;
                edge_dst_m[edge_cnt_m] = it.target_node;
                edge_cnt_m++;
                indeg_m[it.target_node]++;
            end
        end else begin
            for (int i = 1; i <= n; i++) begin
                if (indeg_m[i] == 0) ready_q = {ready_q, t_node'(i)};
            end
            while (ready_q.size() != 0) begin
                now = ready_q.pop_front();
                order_q = {order_q, now};
                for (int e = 0; e < edge_cnt_m; e++) begin
                    if (edge_src_m[e] == now) begin
                        tgt = edge_dst_m[e];
                        if (tgt >= 1 && tgt <= n && indeg_m[tgt] != 0) begin
                            indeg_m[tgt]--;
                            if (indeg_m[tgt] == 0) ready_q = {ready_q, t_node'(tgt)};
                        end
                    end
                end
            end
            if (order_q.size() != n) begin
                r = '{node_id: '0, cycle_found: 1'b1, edge_error: err_sticky_m, last: 1'b1};
                run_res = {run_res, r};
            end else begin
                foreach (order_q[k]) begin
                    r = '{node_id: order_q[k], cycle_found: 1'b0,
                          edge_error: err_sticky_m, last: (k == order_q.size() - 1)};
                    run_res = {run_res, r};
                end
            end
            foreach (indeg_m[k]) indeg_m[k] = 0;
            edge_cnt_m = 0;
        end
    endtask

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_beat(input t_item it, input logic typed, input t_result typed_res);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.payload = it;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        kahn_predict(it);
        if (typed) begin
            expected_order_q = {expected_order_q, typed_res};
        end else begin
            expected_order_q = {expected_order_q, run_res};
        end
        beat_cnt++;
        @(negedge clk);
    endtask

    task automatic send_edge(input t_node s, input t_node d);
        send_beat('{opcode: tse_pkg::OP_ADD_EDGE, source_node: s, target_node: d}, 1'b0, '0);
    endtask

    task automatic send_run();
        send_beat('{opcode: tse_pkg::OP_RUN, source_node: t_node'($urandom),
                    target_node: t_node'($urandom)}, 1'b0, '0);
    endtask

    // engine idle: all results back plus slack for a trailing edge update
    task automatic drain_and_rest();
        in_ch.valid = 1'b0;
        while (expected_order_q.size() != 0) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic set_node_count(input t_node v);
        cfg_ch.valid   = 1'b1;
        cfg_ch.payload = v;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        node_cnt_m = v;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // random graph: mostly acyclic via a random rank order, some cycles, some noise
    task automatic random_graph();
        t_node       perm [NODES_MAX];
        t_node       tmp;
        t_node       raw;
        int unsigned n;
        int unsigned m;
        int          i;
        int          j;
        int          r;
        logic        make_cycle;
        r = $urandom_range(99);
        if ($urandom_range(99) < 60) begin
            if (r < 5)       raw = 7'd1;
            else if (r < 10) raw = ($urandom_range(1) != 0) ? 7'd0 : t_node'($urandom_range(127, 65));
            else if (r < 20) raw = t_node'($urandom_range(64, 17));
            else             raw = t_node'($urandom_range(16, 2));
            drain_and_rest();
            set_node_count(raw);
        end
        n = nodes_eff();
        for (int k = 0; k < n; k++) perm[k] = t_node'(k + 1);
        for (int k = n - 1; k > 0; k--) begin
            j = $urandom_range(k, 0);
            tmp = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
        end
        m = $urandom_range((3 * n < 40) ? 3 * n : 40, 0);
        make_cycle = ($urandom_range(99) < 25);
        for (int k = 0; k < m; k++) begin
            if ($urandom_range(99) < 3) begin
                drain_and_rest();
                set_node_count(t_node'($urandom_range(n, 1)));
            end
            if (n < 2 || $urandom_range(99) < 6) begin
                send_edge(t_node'($urandom), t_node'($urandom));
            end else begin
                i = $urandom_range(n - 2, 0);
                j = $urandom_range(n - 1, i + 1);
                send_edge(perm[i], perm[j]);
            end
        end
        if (make_cycle) begin
            if (n < 2 || $urandom_range(3) == 0) begin
                i = $urandom_range(n - 1, 0);
                send_edge(perm[i], perm[i]);
            end else begin
                i = $urandom_range(n - 2, 0);
                j = $urandom_range(n - 1, i + 1);
                send_edge(perm[j], perm[i]);
            end
        end
        send_run();
        if ($urandom_range(99) < 20) drain_and_rest();
    endtask

    always @(negedge clk) begin
        out_rdy <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk) begin
        t_result want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_rdy) begin
            if (expected_order_q.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, out_ch.payload);
                mismatch_cnt++;
            end else begin
                want = expected_order_q.pop_front();
                if (out_ch.payload.node_id !== want.node_id) begin
                    $display("%0t: node_id expected %0d actual %0d",
                             $time, want.node_id, out_ch.payload.node_id);
                    mismatch_cnt++;
                end
                if (out_ch.payload.cycle_found !== want.cycle_found) begin
                    $display("%0t: cycle_found expected %b actual %b",
                             $time, want.cycle_found, out_ch.payload.cycle_found);
                    mismatch_cnt++;
                end
                if (out_ch.payload.edge_error !== want.edge_error) begin
                    $display("%0t: edge_error expected %b actual %b",
                             $time, want.edge_error, out_ch.payload.edge_error);
                    mismatch_cnt++;
                end
                if (out_ch.payload.last !== want.last) begin
                    $display("%0t: last expected %b actual %b",
                             $time, want.last, out_ch.payload.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int rand_start;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        edge_cnt_m     = 0;
        err_sticky_m   = 1'b0;
        node_cnt_m     = tse_pkg::NODE_CNT_RST;
        foreach (indeg_m[k]) indeg_m[k] = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            case (DIR_TAB[k].kind)
                ROW_CFG: begin
                    drain_and_rest();
                    set_node_count(DIR_TAB[k].a);
                end
                ROW_EDGE: begin
                    send_edge(DIR_TAB[k].a, DIR_TAB[k].b);
                end
                default: begin
                    send_beat('{opcode: tse_pkg::OP_RUN, source_node: DIR_TAB[k].a,
                                target_node: DIR_TAB[k].b},
                              DIR_TAB[k].typed, DIR_TAB[k].res);
                end
            endcase
        end

        rand_start = beat_cnt;
        while (beat_cnt - rand_start < RAND_BEATS / 3) random_graph();

        // fill the edge store past capacity on the widest graph
        drain_and_rest();
        set_node_count(7'd64);
        for (int k = 0; k < EDGES_MAX + 4; k++) begin
            send_edge(t_node'($urandom_range(32, 1)), t_node'($urandom_range(64, 33)));
        end
        send_run();
        drain_and_rest();

        rand_start = beat_cnt;
        snd_idle_pct = 45;
        rcv_idle_pct = 23;
        while (beat_cnt - rand_start < RAND_BEATS / 3) random_graph();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        while (beat_cnt - rand_start < RAND_BEATS - RAND_BEATS / 3) random_graph();

        drain_and_rest();
        repeat (20) @(negedge clk);
        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
